// ===== hdl/skt_pkg.sv =====
// Shared constants and types for the sorted key table.
package skt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 16;
    localparam int MASK_BITS   = 16;
    localparam int KEY_IN_BITS = 16;
    localparam int COUNT_BITS  = 6;
    localparam int STATUS_BITS = 3;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + 2 * MASK_BITS;

    localparam logic [STATUS_BITS-1:0] STATUS_UPDATED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_INSERTED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_DELETED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd4;

    localparam logic KIND_SET    = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [MASK_BITS-1:0] mask_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]     idx_t;

    typedef struct packed {
        key_t  key;
        mask_t event_mask;
        mask_t returned_mask;
    } entry_t;

endpackage

// ===== hdl/sorted_key_table_top.sv =====
// Sorted key table: top level with scan, shift and result control.
// One request at a time: a scan reads the entries in order until it finds the key's place,
// then an insert or delete moves the entries behind that place by one slot, and then the
// result is registered for output.
// A new request is taken while the previous result still waits in the output register.
// Reset clears the entry count and handshake state; the entry RAM is not cleared.
module sorted_key_table_top
    import skt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_key[15:0], event_mask[31:16], returned_mask[47:32]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // entry_count[5:0], status[8:6], zero fill
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_PUT    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]             state_reg, state_next;
    count_t                 used_reg, used_next;
    count_t                 cur_reg, cur_next;
    count_t                 cmp_idx_reg, cmp_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    count_t                 pos_reg, pos_next;
    logic                   hit_reg, hit_next;
    logic                   pend_valid_reg, pend_valid_next;
    idx_t                   pend_addr_reg, pend_addr_next;
    logic                   kind_reg, kind_next;
    entry_t                 item_reg, item_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [15:0]            m_data_reg, m_data_next;

    logic   ram_we;
    idx_t   ram_waddr;
    entry_t ram_wdata;
    idx_t   ram_raddr;
    entry_t ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_bits;

    assign ram_rdata = entry_t'(ram_rdata_bits);

    skt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_bits)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        kind_next       = kind_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = cur_reg[IDX_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next                = s_tuser;
                    item_next.key            = s_tdata[KEY_BITS-1:0];
                    item_next.event_mask     = s_tdata[KEY_IN_BITS +: MASK_BITS];
                    item_next.returned_mask  = s_tdata[KEY_IN_BITS + MASK_BITS +: MASK_BITS];
                    cur_next                 = '0;
                    state_next               = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cmp_valid_reg && (ram_rdata.key >= item_reg.key)) begin
                    pos_next   = cmp_idx_reg;
                    hit_next   = (ram_rdata.key == item_reg.key);
                    state_next = ST_DECIDE;
                end else if (cur_reg == used_reg) begin
                    pos_next   = used_reg;
                    hit_next   = 1'b0;
                    state_next = ST_DECIDE;
                end else begin
                    ram_raddr      = cur_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = cur_reg;
                    cur_next       = cur_reg + count_t'(1);
                end
            end
            ST_DECIDE: begin
                pend_valid_next = 1'b0;
                if (kind_reg == KIND_SET) begin
                    if (hit_reg) begin
                        ram_we      = 1'b1;
                        ram_waddr   = pos_reg[IDX_W-1:0];
                        ram_wdata   = item_reg;
                        status_next = STATUS_UPDATED;
                        state_next  = ST_FINISH;
                    end else if (used_reg == count_t'(TABLE_DEPTH)) begin
                        status_next = STATUS_FULL;
                        state_next  = ST_FINISH;
                    end else begin
                        cur_next   = used_reg;
                        state_next = ST_SHIFT;
                    end
                end else begin
                    if (hit_reg) begin
                        cur_next   = pos_reg + count_t'(1);
                        state_next = ST_SHIFT;
                    end else begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_SHIFT: begin
                // move one entry per cycle: read ahead, write the previous read
                if (pend_valid_reg) begin
                    ram_we          = 1'b1;
                    ram_waddr       = pend_addr_reg;
                    ram_wdata       = ram_rdata;
                    pend_valid_next = 1'b0;
                end
                if (kind_reg == KIND_SET) begin
                    if (cur_reg > pos_reg) begin
                        ram_raddr       = IDX_W'(cur_reg - count_t'(1));
                        pend_valid_next = 1'b1;
                        pend_addr_next  = cur_reg[IDX_W-1:0];
                        cur_next        = cur_reg - count_t'(1);
                    end else if (!pend_valid_reg) begin
                        state_next = ST_PUT;
                    end
                end else begin
                    if (cur_reg < used_reg) begin
                        ram_raddr       = cur_reg[IDX_W-1:0];
                        pend_valid_next = 1'b1;
                        pend_addr_next  = IDX_W'(cur_reg - count_t'(1));
                        cur_next        = cur_reg + count_t'(1);
                    end else if (!pend_valid_reg) begin
                        used_next   = used_reg - count_t'(1);
                        status_next = STATUS_DELETED;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_PUT: begin
                ram_we      = 1'b1;
                ram_waddr   = pos_reg[IDX_W-1:0];
                ram_wdata   = item_reg;
                used_next   = used_reg + count_t'(1);
                status_next = STATUS_INSERTED;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, status_reg, COUNT_BITS'(used_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        cmp_idx_reg   <= cmp_idx_next;
        pos_reg       <= pos_next;
        hit_reg       <= hit_next;
        pend_addr_reg <= pend_addr_next;
        kind_reg      <= kind_next;
        item_reg      <= item_next;
        status_reg    <= status_next;
        m_data_reg    <= m_data_next;
    end

endmodule

// ===== hdl/skt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
